FILE: hw/rtl/rau_pkg.sv
// types, codes and widths shared by the rational arithmetic unit
package rau_pkg;

   localparam int WIDTH  = 32;
   localparam int DWIDTH = 2 * WIDTH;
   localparam int GKW    = $clog2(DWIDTH);
   localparam int DCW    = $clog2(DWIDTH + 1);

   localparam logic [1:0] CMD_MUL = 2'd0;
   localparam logic [1:0] CMD_DIV = 2'd1;
   localparam logic [1:0] CMD_ADD = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_ZERO_DEN = 2'd2;

   typedef struct packed {
      logic [1:0]              cmd;
      logic signed [WIDTH-1:0] num_a;
      logic signed [WIDTH-1:0] den_a;
      logic signed [WIDTH-1:0] num_b;
      logic signed [WIDTH-1:0] den_b;
   } req_type;

   typedef struct packed {
      logic signed [WIDTH-1:0] res_num;
      logic signed [WIDTH-1:0] res_den;
      logic [1:0]              status;
   } rsp_type;

   typedef enum logic [4:0] {
      DP_IDLE, DP_LOAD, DP_ZERO_DEN, DP_MUL_N, DP_MUL_T, DP_SUM, DP_MUL_D,
      DP_GCD_DEN, DP_GCD_RES, DP_GCD_STEP, DP_DIV_QA, DP_DIV_QB, DP_DIV_N,
      DP_DIV_D, DP_DIV_STEP, DP_PUT_QA, DP_PUT_QB, DP_PUT_N, DP_PUT_D, DP_FINISH
   } dp_op_type;

   typedef struct packed {
      logic is_add;
      logic den_zero;
      logic gcd_done;
      logic gcd_zero;
      logic div_done;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_GCD_A, S_DIV_QA, S_LOAD_QB, S_DIV_QB, S_MUL_N, S_MUL_T,
      S_SUM, S_MUL_D, S_GCD_LOAD, S_GCD_R, S_DIV_N, S_LOAD_D, S_DIV_D, S_FIN,
      S_DONE
   } state_type;

endpackage

FILE: hw/rtl/rau_ctrl.sv
// sequencer for the rational arithmetic unit
module rau_ctrl import rau_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type dp_status,
   output dp_op_type     dp_op,
   output logic          busy,
   output logic          rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dp_op    = DP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               dp_op    = DP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (dp_status.is_add) begin
               if (dp_status.den_zero) begin
                  dp_op    = DP_ZERO_DEN;
                  state_in = S_DONE;
               end else begin
                  dp_op    = DP_GCD_DEN;
                  state_in = S_GCD_A;
               end
            end else begin
               dp_op    = DP_MUL_N;
               state_in = S_MUL_D;
            end
         end
         S_GCD_A: begin
            if (dp_status.gcd_done) begin
               dp_op    = DP_DIV_QA;
               state_in = S_DIV_QA;
            end else begin
               dp_op = DP_GCD_STEP;
            end
         end
         S_DIV_QA: begin
            if (dp_status.div_done) begin
               dp_op    = DP_PUT_QA;
               state_in = S_LOAD_QB;
            end else begin
               dp_op = DP_DIV_STEP;
            end
         end
         S_LOAD_QB: begin
            dp_op    = DP_DIV_QB;
            state_in = S_DIV_QB;
         end
         S_DIV_QB: begin
            if (dp_status.div_done) begin
               dp_op    = DP_PUT_QB;
               state_in = S_MUL_N;
            end else begin
               dp_op = DP_DIV_STEP;
            end
         end
         S_MUL_N: begin
            dp_op    = DP_MUL_N;
            state_in = S_MUL_T;
         end
         S_MUL_T: begin
            dp_op    = DP_MUL_T;
            state_in = S_SUM;
         end
         S_SUM: begin
            dp_op    = DP_SUM;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            dp_op    = DP_MUL_D;
            state_in = S_GCD_LOAD;
         end
         S_GCD_LOAD: begin
            dp_op    = DP_GCD_RES;
            state_in = S_GCD_R;
         end
         S_GCD_R: begin
            if (dp_status.gcd_done) begin
               // gcd of zero means 0/0, left unreduced
               if (dp_status.gcd_zero) begin
                  dp_op    = DP_FINISH;
                  state_in = S_DONE;
               end else begin
                  dp_op    = DP_DIV_N;
                  state_in = S_DIV_N;
               end
            end else begin
               dp_op = DP_GCD_STEP;
            end
         end
         S_DIV_N: begin
            if (dp_status.div_done) begin
               dp_op    = DP_PUT_N;
               state_in = S_LOAD_D;
            end else begin
               dp_op = DP_DIV_STEP;
            end
         end
         S_LOAD_D: begin
            dp_op    = DP_DIV_D;
            state_in = S_DIV_D;
         end
         S_DIV_D: begin
            if (dp_status.div_done) begin
               dp_op    = DP_PUT_D;
               state_in = S_FIN;
            end else begin
               dp_op = DP_DIV_STEP;
            end
         end
         S_FIN: begin
            dp_op    = DP_FINISH;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule

FILE: hw/rtl/rau_datapath.sv
// operand registers, shared multiplier, binary gcd and restoring divider
module rau_datapath import rau_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_op_type     dp_op,
   input  req_type       req_data,
   output dp_status_type dp_status,
   output rsp_type       rsp_data
);

   logic              is_add_ff, is_div_ff;
   logic              sa_n_ff, sa_d_ff, sb_n_ff, sb_d_ff;
   logic [WIDTH-1:0]  ma_n_ff, ma_d_ff, mb_n_ff, mb_d_ff;
   logic [WIDTH-1:0]  qa_ff, qb_ff;
   logic              n_neg_ff, d_neg_ff, t_neg_ff;
   logic [DWIDTH-1:0] n_mag_ff, d_mag_ff, t_mag_ff;
   logic [DWIDTH-1:0] ga_ff, gb_ff;
   logic [GKW-1:0]    gk_ff;
   logic [DWIDTH-1:0] rem_ff, quo_ff, dvsr_ff;
   logic [DCW-1:0]    cnt_ff;
   rsp_type           rsp_ff;

   logic [WIDTH-1:0]  mul_a, mul_b;
   logic [DWIDTH-1:0] prod;
   logic [DWIDTH-1:0] gcd_g;
   logic [DWIDTH:0]   trial;
   logic              trial_ge;
   logic [DWIDTH-1:0] n_out, d_out;
   logic              n_fits, d_fits;
   logic [DWIDTH-1:0] lim;

   function automatic logic [WIDTH-1:0] field_mag(input logic [WIDTH-1:0] x);
      return x[WIDTH-1] ? (~x + 1'b1) : x;
   endfunction

   // one multiplier, operands chosen by the current step
   always_comb begin
      mul_a = ma_n_ff;
      mul_b = mb_n_ff;
      case (dp_op)
         DP_MUL_N: begin
            mul_a = ma_n_ff;
            mul_b = is_add_ff ? qa_ff : (is_div_ff ? mb_d_ff : mb_n_ff);
         end
         DP_MUL_T: begin
            mul_a = mb_n_ff;
            mul_b = qb_ff;
         end
         DP_MUL_D: begin
            mul_a = is_add_ff ? qb_ff : ma_d_ff;
            mul_b = is_add_ff ? mb_d_ff : (is_div_ff ? mb_n_ff : mb_d_ff);
         end
         default: begin
            mul_a = ma_n_ff;
            mul_b = mb_n_ff;
         end
      endcase
   end

   assign prod     = DWIDTH'(mul_a) * DWIDTH'(mul_b);
   assign gcd_g    = ga_ff | gb_ff;
   assign trial    = {rem_ff, quo_ff[DWIDTH-1]};
   assign trial_ge = (trial >= {1'b0, dvsr_ff});

   assign lim    = DWIDTH'(1) << (WIDTH - 1);
   assign n_fits = n_neg_ff ? (n_mag_ff <= lim) : (n_mag_ff < lim);
   assign d_fits = d_neg_ff ? (d_mag_ff <= lim) : (d_mag_ff < lim);
   assign n_out  = n_neg_ff ? (~n_mag_ff + 1'b1) : n_mag_ff;
   assign d_out  = d_neg_ff ? (~d_mag_ff + 1'b1) : d_mag_ff;

   always_ff @(posedge clock) begin
      case (dp_op)
         DP_LOAD: begin
            is_add_ff <= req_data.cmd[1];
            is_div_ff <= (req_data.cmd == CMD_DIV);
            sa_n_ff   <= req_data.num_a[WIDTH-1];
            sa_d_ff   <= req_data.den_a[WIDTH-1];
            sb_n_ff   <= req_data.num_b[WIDTH-1];
            sb_d_ff   <= req_data.den_b[WIDTH-1];
            ma_n_ff   <= field_mag(req_data.num_a);
            ma_d_ff   <= field_mag(req_data.den_a);
            mb_n_ff   <= field_mag(req_data.num_b);
            mb_d_ff   <= field_mag(req_data.den_b);
         end
         DP_MUL_N: begin
            n_mag_ff <= prod;
            n_neg_ff <= sa_n_ff ^ (is_add_ff ? sa_d_ff : (is_div_ff ? sb_d_ff : sb_n_ff));
         end
         DP_MUL_T: begin
            t_mag_ff <= prod;
            t_neg_ff <= sb_n_ff ^ sb_d_ff;
         end
         DP_MUL_D: begin
            d_mag_ff <= prod;
            d_neg_ff <= is_add_ff ? 1'b0 : (sa_d_ff ^ (is_div_ff ? sb_n_ff : sb_d_ff));
         end
         DP_SUM: begin
            // signed-magnitude add, zero comes out positive
            if (n_neg_ff == t_neg_ff) begin
               n_mag_ff <= n_mag_ff + t_mag_ff;
               n_neg_ff <= (n_mag_ff + t_mag_ff == '0) ? 1'b0 : n_neg_ff;
            end else if (n_mag_ff >= t_mag_ff) begin
               n_mag_ff <= n_mag_ff - t_mag_ff;
               n_neg_ff <= (n_mag_ff == t_mag_ff) ? 1'b0 : n_neg_ff;
            end else begin
               n_mag_ff <= t_mag_ff - n_mag_ff;
               n_neg_ff <= t_neg_ff;
            end
         end
         DP_GCD_DEN: begin
            ga_ff <= DWIDTH'(ma_d_ff);
            gb_ff <= DWIDTH'(mb_d_ff);
            gk_ff <= '0;
         end
         DP_GCD_RES: begin
            ga_ff <= n_mag_ff;
            gb_ff <= d_mag_ff;
            gk_ff <= '0;
         end
         DP_GCD_STEP: begin
            if (ga_ff == '0 || gb_ff == '0) begin
               // restore the common factors of two
               ga_ff <= gcd_g << 1;
               gb_ff <= '0;
               gk_ff <= gk_ff - 1'b1;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_ff <= ga_ff >> 1;
               gb_ff <= gb_ff >> 1;
               gk_ff <= gk_ff + 1'b1;
            end else if (!ga_ff[0]) begin
               ga_ff <= ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_ff <= gb_ff >> 1;
            end else if (ga_ff >= gb_ff) begin
               ga_ff <= (ga_ff - gb_ff) >> 1;
            end else begin
               gb_ff <= (gb_ff - ga_ff) >> 1;
            end
         end
         DP_DIV_QA, DP_DIV_QB, DP_DIV_N, DP_DIV_D: begin
            rem_ff  <= '0;
            dvsr_ff <= gcd_g;
            case (dp_op)
               DP_DIV_QA: quo_ff <= DWIDTH'(mb_d_ff);
               DP_DIV_QB: quo_ff <= DWIDTH'(ma_d_ff);
               DP_DIV_N:  quo_ff <= n_mag_ff;
               default:   quo_ff <= d_mag_ff;
            endcase
         end
         DP_DIV_STEP: begin
            rem_ff <= trial_ge ? DWIDTH'(trial - {1'b0, dvsr_ff}) : trial[DWIDTH-1:0];
            quo_ff <= {quo_ff[DWIDTH-2:0], trial_ge};
         end
         DP_PUT_QA: qa_ff    <= quo_ff[WIDTH-1:0];
         DP_PUT_QB: qb_ff    <= quo_ff[WIDTH-1:0];
         DP_PUT_N:  n_mag_ff <= quo_ff;
         DP_PUT_D:  d_mag_ff <= quo_ff;
         DP_ZERO_DEN: begin
            rsp_ff.res_num <= '0;
            rsp_ff.res_den <= '0;
            rsp_ff.status  <= ST_ZERO_DEN;
         end
         DP_FINISH: begin
            rsp_ff.res_num <= n_out[WIDTH-1:0];
            rsp_ff.res_den <= d_out[WIDTH-1:0];
            rsp_ff.status  <= (n_fits && d_fits) ? ST_OK : ST_OVERFLOW;
         end
         default: begin
         end
      endcase
   end

   // divider step counter is control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (dp_op == DP_DIV_QA || dp_op == DP_DIV_QB ||
                   dp_op == DP_DIV_N || dp_op == DP_DIV_D) begin
         cnt_ff <= DCW'(DWIDTH);
      end else if (dp_op == DP_DIV_STEP) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign dp_status.is_add   = is_add_ff;
   assign dp_status.den_zero = (ma_d_ff == '0) || (mb_d_ff == '0);
   assign dp_status.gcd_done = (ga_ff == '0 || gb_ff == '0) && (gk_ff == '0);
   assign dp_status.gcd_zero = (gcd_g == '0);
   assign dp_status.div_done = (cnt_ff == '0);
   assign rsp_data           = rsp_ff;

endmodule

FILE: hw/rtl/rational_arith_unit.sv
// top level of the rational arithmetic unit
// Fraction multiply, divide and add with gcd reduction. A word is taken when
// start is high while busy is low; one item is worked on at a time and busy
// stays high until its result has been shown. The result is shown for one
// cycle with rsp_valid and cannot be held off. Work runs through the shared
// 64-step restoring divider and the binary gcd loop. A zero denominator in add
// goes from the check straight to the result with no gcd pass or division;
// a 0/0 result skips both reduction divisions.
module rational_arith_unit import rau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   dp_op_type     dp_op;
   dp_status_type dp_status;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .dp_op     (dp_op),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   rau_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .dp_op     (dp_op),
      .req_data  (req_data),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/rau_checker.sv
// port-level checks for the rational arithmetic unit
module rau_checker import rau_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_ZERO_DEN) |->
         (rsp_data.res_num == '0 && rsp_data.res_den == '0))
      else $error("zero denominator result not cleared");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_OVERFLOW ||
                     rsp_data.status == ST_ZERO_DEN))
      else $error("unknown status code");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);
